[rtl/core/ptd_pkg.sv]
// Shared types and constants for the pending task dispatcher.
package ptd_pkg;

	// Field widths fixed by the command and response words.
	localparam int KIND_W = 3;
	localparam int IDX_W = 6;
	localparam int ARG_W = 8;
	localparam int DELAY_W = 16;
	localparam int COUNT_W = 12;

	// Longest delay accepted, and the tick period as a shift (16 ms).
	localparam logic [DELAY_W-1:0] MAX_DELAY_MS = 16'd65520;
	localparam int TICK_SHIFT = 4;

	// Command kinds. Codes 5 to 7 are accepted and ignored.
	typedef enum logic [KIND_W-1:0] {
		KIND_TICK  = 3'd0,
		KIND_POST  = 3'd1,
		KIND_START = 3'd2,
		KIND_STOP  = 3'd3,
		KIND_FETCH = 3'd4
	} kind_t;

	// Slot set selector.
	localparam logic TYPE_APP = 1'b0;
	localparam logic TYPE_TIMER = 1'b1;

	// Controller state.
	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// Command word.
	typedef struct packed {
		kind_t             kind;
		logic              task_type;
		logic [IDX_W-1:0]  task_index;
		logic [ARG_W-1:0]  task_arg;
		logic [DELAY_W-1:0] delay_ms;
	} cmd_word_t;

	// Response word.
	typedef struct packed {
		logic             found;
		logic             served_type;
		logic [IDX_W-1:0] served_index;
		logic [ARG_W-1:0] served_arg;
	} rsp_word_t;

	// Control broadcast from the controller to every slot cell.
	typedef struct packed {
		logic               post;
		logic               start;
		logic               stop;
		logic               tick;
		logic               advance;
		logic               serve;
		logic               rewind;
		logic               task_type;
		logic [IDX_W-1:0]   task_index;
		logic [ARG_W-1:0]   task_arg;
		logic [COUNT_W-1:0] delay_units;
	} ptd_ctl_t;

endpackage

[rtl/core/ptd_cell.sv]
// One task slot of the dispatcher ring: pending flag, argument, optional countdown, scan token.
module ptd_cell #(
	parameter bit IS_TIMER = 1'b0,
	parameter int SLOT_IDX = 0,
	parameter bit IS_FIRST = 1'b0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ptd_pkg::ptd_ctl_t        ctl,
	input  logic                     token_in,
	output logic                     token,
	output logic                     hit,
	output logic [ptd_pkg::ARG_W-1:0] arg_out
);
	import ptd_pkg::*;

	logic             pending_q;
	logic [ARG_W-1:0] arg_q;
	logic             token_q;
	logic             sel;
	logic             post_hit;
	logic             expire;

	// Address match for post, start and stop.
	assign sel = (ctl.task_index == IDX_W'(SLOT_IDX));
	assign post_hit = ctl.post && (ctl.task_type == IS_TIMER) && sel;

	// Countdown, present only in timer slots.
	if (IS_TIMER) begin : g_timer
		logic [COUNT_W-1:0] count_q;

		assign expire = ctl.tick && (count_q == COUNT_W'(1));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				count_q <= '0;
			end else if (ctl.start && sel) begin
				count_q <= ctl.delay_units;
			end else if (ctl.stop && sel) begin
				count_q <= '0;
			end else if (ctl.tick && (count_q != '0)) begin
				count_q <= count_q - COUNT_W'(1);
			end
		end
	end else begin : g_app
		assign expire = 1'b0;
	end

	// Pending flag and argument. Posts and expiries never coincide with a serve.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			arg_q <= '0;
		end else begin
			if (post_hit) begin
				arg_q <= ctl.task_arg;
			end
			if (post_hit || expire) begin
				pending_q <= 1'b1;
			end else if (ctl.serve && token_q) begin
				pending_q <= 1'b0;
			end
		end
	end

	// The scan token walks the ring one cell per cycle while advance is set, or returns to the first cell on rewind.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= IS_FIRST;
		end else if (ctl.rewind) begin
			token_q <= IS_FIRST;
		end else if (ctl.advance) begin
			token_q <= token_in;
		end
	end

	assign token = token_q;
	assign hit = token_q && pending_q;
	assign arg_out = token_q ? arg_q : '0;

endmodule

[rtl/core/pending_task_dispatch_with_timers.sv]
// Top level of the pending task dispatcher: decode, scan control, slot ring, response register.
//
// The block holds APP_SLOTS app slots followed by TIMER_SLOTS timer slots as a ring of cells;
// a one-hot scan token sits at the current round-robin position. Tick, post, start, stop and
// unknown kinds are acted on as they are taken. A fetch then walks the token one cell per
// cycle from the slot after the last one served until it finds a pending slot or has visited
// every slot, and also waits while the response register still holds an untaken word.
// Commands are accepted only while no fetch is in progress; the response register lets a new
// command enter while a result waits.
module pending_task_dispatch_with_timers #(
	parameter int APP_SLOTS = 8,
	parameter int TIMER_SLOTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  ptd_pkg::cmd_word_t cmd,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output ptd_pkg::rsp_word_t rsp
);
	import ptd_pkg::*;

	localparam int ALL_SLOTS = APP_SLOTS + TIMER_SLOTS;
	localparam int SCAN_W = $clog2(ALL_SLOTS);

	state_t            state_q;
	state_t            state_d;
	logic [SCAN_W-1:0] scan_cnt_q;
	logic [SCAN_W-1:0] scan_cnt_d;
	logic              rsp_valid_q;
	rsp_word_t         rsp_q;
	logic              rsp_load;
	rsp_word_t         rsp_d;
	ptd_ctl_t          ctl;
	logic              accept;
	logic              can_emit;
	logic              last;
	logic              any_hit;
	logic [DELAY_W-1:0] delay_clamped;

	logic [ALL_SLOTS-1:0] token;
	logic [ALL_SLOTS-1:0] hit;
	logic [ARG_W-1:0]     cell_arg [ALL_SLOTS];
	logic [ARG_W-1:0]     sel_arg;
	logic                 sel_type;
	logic [IDX_W-1:0]     sel_index;

	// Ring of slot cells; each takes the token from its predecessor.
	for (genvar i = 0; i < ALL_SLOTS; i++) begin : g_cell
		localparam int PREV = (i == 0) ? ALL_SLOTS - 1 : i - 1;

		ptd_cell #(
			.IS_TIMER(i >= APP_SLOTS),
			.SLOT_IDX((i < APP_SLOTS) ? i : i - APP_SLOTS),
			.IS_FIRST(i == 0)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.token_in(token[PREV]),
			.token   (token[i]),
			.hit     (hit[i]),
			.arg_out (cell_arg[i])
		);
	end

	// Gather the slot under the token: its set, its number and its argument.
	always_comb begin
		sel_arg = '0;
		sel_type = TYPE_APP;
		sel_index = '0;
		for (int i = 0; i < ALL_SLOTS; i++) begin
			sel_arg = sel_arg | cell_arg[i];
			if (token[i]) begin
				sel_type = (i >= APP_SLOTS) ? TYPE_TIMER : TYPE_APP;
				sel_index = (i >= APP_SLOTS) ? IDX_W'(i - APP_SLOTS) : IDX_W'(i);
			end
		end
	end

	assign any_hit = |hit;
	assign accept = cmd_valid && cmd_ready;
	assign cmd_ready = (state_q == ST_IDLE);
	assign can_emit = !rsp_valid_q || rsp_ready;
	assign last = (scan_cnt_q == SCAN_W'(ALL_SLOTS - 1));

	// Delays beyond the limit are clamped, then converted to 16 ms ticks.
	assign delay_clamped = (cmd.delay_ms > MAX_DELAY_MS) ? MAX_DELAY_MS : cmd.delay_ms;

	// Controller state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			scan_cnt_q <= scan_cnt_d;
		end
	end

	// Command decode, scan stepping and response staging.
	always_comb begin
		state_d = state_q;
		scan_cnt_d = scan_cnt_q;
		rsp_load = 1'b0;
		rsp_d = '0;
		ctl = '0;
		ctl.task_type = cmd.task_type;
		ctl.task_index = cmd.task_index;
		ctl.task_arg = cmd.task_arg;
		ctl.delay_units = delay_clamped[TICK_SHIFT +: COUNT_W];
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd.kind)
						KIND_TICK: ctl.tick = 1'b1;
						KIND_POST: ctl.post = 1'b1;
						KIND_START: ctl.start = 1'b1;
						KIND_STOP: ctl.stop = 1'b1;
						KIND_FETCH: begin
							state_d = ST_SCAN;
							scan_cnt_d = '0;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				priority if (any_hit) begin
					if (can_emit) begin
						ctl.serve = 1'b1;
						ctl.advance = 1'b1;
						rsp_load = 1'b1;
						rsp_d.found = 1'b1;
						rsp_d.served_type = sel_type;
						rsp_d.served_index = sel_index;
						rsp_d.served_arg = sel_arg;
						state_d = ST_IDLE;
					end
				end else if (!last) begin
					ctl.advance = 1'b1;
					scan_cnt_d = scan_cnt_q + SCAN_W'(1);
				end else if (can_emit) begin
					// Nothing pending anywhere: report none and restart at the first app slot.
					ctl.rewind = 1'b1;
					rsp_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: ;
		endcase
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`ifndef NO_ASSERTIONS
	// Exactly one cell holds the scan token at all times.
	a_token_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(token))
		else $error("scan token is not one-hot");

	// A fetch that finds nothing leaves the token on the first app slot.
	a_rewind_first: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && !any_hit && last && can_emit) |=> token[0])
		else $error("scan did not rewind to the first slot");

	// A served slot is no longer pending in the cycle after it is served.
	a_served_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && any_hit && can_emit) |=> ((hit & $past(token)) == '0))
		else $error("served slot still pending");

	// The miss counter never runs past the ring length.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_cnt_q <= SCAN_W'(ALL_SLOTS - 1))
		else $error("scan counter out of range");
`endif

endmodule

[verif/dispatch_checker.sv]
// Reply checker for the pending task dispatcher: tracks slot state and compares every reply word.
module dispatch_checker #(
	parameter int APP_SLOTS = 8,
	parameter int TIMER_SLOTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_ready,
	input  ptd_pkg::cmd_word_t cmd,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  ptd_pkg::rsp_word_t rsp,
	output int                 fail_count,
	output int                 waiting,
	output int                 served_count,
	output int                 empty_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import ptd_pkg::*;

	localparam int ALL_SLOTS = APP_SLOTS + TIMER_SLOTS;

	// Shadow copy of the dispatcher state.
	logic               app_flag [APP_SLOTS];
	logic [ARG_W-1:0]   app_arg [APP_SLOTS];
	logic               timer_flag [TIMER_SLOTS];
	logic [ARG_W-1:0]   timer_arg [TIMER_SLOTS];
	logic [COUNT_W-1:0] timer_count [TIMER_SLOTS];
	int                 scan_pos;

	// Reply words owed by the block, oldest first.
	rsp_word_t awaited_replies[$];

	// Apply one accepted command word to the shadow state and queue any reply it owes.
	task automatic apply_command(input cmd_word_t c);
		logic [DELAY_W-1:0] ms;
		rsp_word_t r;
		int pos;
		bit hit;
		r = '0;
		hit = 1'b0;
		case (c.kind)
			KIND_TICK: begin
				for (int i = 0; i < TIMER_SLOTS; i++) begin
					if (timer_count[i] != '0) begin
						timer_count[i] = timer_count[i] - COUNT_W'(1);
						if (timer_count[i] == '0)
							timer_flag[i] = 1'b1;
					end
				end
			end
			KIND_POST: begin
				if (c.task_type == TYPE_APP) begin
					if (c.task_index < APP_SLOTS) begin
						app_arg[c.task_index] = c.task_arg;
						app_flag[c.task_index] = 1'b1;
					end
				end else if (c.task_index < TIMER_SLOTS) begin
					timer_arg[c.task_index] = c.task_arg;
					timer_flag[c.task_index] = 1'b1;
				end
			end
			KIND_START: begin
				// Long delays saturate; the countdown is in 16 ms units.
				ms = (c.delay_ms > MAX_DELAY_MS) ? MAX_DELAY_MS : c.delay_ms;
				if (c.task_index < TIMER_SLOTS)
					timer_count[c.task_index] = COUNT_W'(ms >> TICK_SHIFT);
			end
			KIND_STOP: begin
				if (c.task_index < TIMER_SLOTS)
					timer_count[c.task_index] = '0;
			end
			KIND_FETCH: begin
				// Round-robin walk from the slot after the last one served.
				pos = (scan_pos < ALL_SLOTS) ? scan_pos : 0;
				for (int n = 0; n < ALL_SLOTS && !hit; n++) begin
					if (pos < APP_SLOTS) begin
						if (app_flag[pos]) begin
							app_flag[pos] = 1'b0;
							hit = 1'b1;
							r.found = 1'b1;
							r.served_type = TYPE_APP;
							r.served_index = IDX_W'(pos);
							r.served_arg = app_arg[pos];
						end
					end else if (timer_flag[pos - APP_SLOTS]) begin
						timer_flag[pos - APP_SLOTS] = 1'b0;
						hit = 1'b1;
						r.found = 1'b1;
						r.served_type = TYPE_TIMER;
						r.served_index = IDX_W'(pos - APP_SLOTS);
						r.served_arg = timer_arg[pos - APP_SLOTS];
					end
					pos = (pos + 1 < ALL_SLOTS) ? pos + 1 : 0;
				end
				// An empty walk rewinds the scan to the first app slot.
				scan_pos = hit ? pos : 0;
				awaited_replies.push_back(r);
			end
			default: begin
			end
		endcase
	endtask

	// Compare replies first, since a reply can never belong to a command taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		rsp_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < APP_SLOTS; i++) begin
				app_flag[i] = 1'b0;
				app_arg[i] = '0;
			end
			for (int i = 0; i < TIMER_SLOTS; i++) begin
				timer_flag[i] = 1'b0;
				timer_arg[i] = '0;
				timer_count[i] = '0;
			end
			scan_pos = 0;
			awaited_replies.delete();
			fail_count = 0;
			waiting = 0;
			served_count = 0;
			empty_count = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_replies.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected reply: found=%0b type=%0b index=%0d arg=%02h",
						$time, rsp.found, rsp.served_type, rsp.served_index, rsp.served_arg);
				end else begin
					want = awaited_replies.pop_front();
					if (want.found)
						served_count++;
					else
						empty_count++;
					if (rsp.found !== want.found || rsp.served_type !== want.served_type ||
							rsp.served_index !== want.served_index ||
							rsp.served_arg !== want.served_arg) begin
						fail_count++;
						$display("%0t: expected f=%0b t=%0b i=%0d a=%02h, got f=%0b t=%0b i=%0d a=%02h",
							$time, want.found, want.served_type, want.served_index,
							want.served_arg, rsp.found, rsp.served_type, rsp.served_index,
							rsp.served_arg);
					end
				end
			end
			if (cmd_valid && cmd_ready)
				apply_command(cmd);
			waiting = awaited_replies.size();
		end
	end

endmodule

[verif/pending_task_dispatch_with_timers_test.sv]
// Stimulus and verdict for the pending task dispatcher: directed, pressure and random command words.
module pending_task_dispatch_with_timers_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ptd_pkg::*;

	localparam int APP_SLOTS = 8;
	localparam int TIMER_SLOTS = 8;
	localparam int PHASE_ITEMS = 200;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 2 * (APP_SLOTS + TIMER_SLOTS) + 8;
	localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd5;
	localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_word_t cmd = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_word_t rsp;

	int send_gap_pct = 0;
	int reply_stall_pct = 0;
	bit hold_off_req = 1'b0;
	int hold_left = 0;
	int sent_count = 0;
	int fail_count;
	int waiting;
	int served_count;
	int empty_count;

	pending_task_dispatch_with_timers #(
		.APP_SLOTS(APP_SLOTS),
		.TIMER_SLOTS(TIMER_SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	dispatch_checker #(
		.APP_SLOTS(APP_SLOTS),
		.TIMER_SLOTS(TIMER_SLOTS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.fail_count(fail_count),
		.waiting(waiting),
		.served_count(served_count),
		.empty_count(empty_count)
	);

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	initial begin
		#4000000;
		$display("pending_task_dispatch_with_timers regression: fail");
		$finish;
	end

	// Reply side: random stalls, or a long hold-off counted here when one is requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left--;
		end else if (hold_off_req) begin
			hold_off_req = 1'b0;
			hold_left = HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= reply_stall_pct);
		end
	end

	function automatic cmd_word_t make_word(kind_t k, logic t, int idx, int arg, int ms);
		cmd_word_t w;
		w.kind = k;
		w.task_type = t;
		w.task_index = IDX_W'(idx);
		w.task_arg = ARG_W'(arg);
		w.delay_ms = DELAY_W'(ms);
		return w;
	endfunction

	// Offer one command word after a random gap and hold it until the block takes it.
	task automatic send_word(input cmd_word_t w);
		while ($urandom_range(99) < send_gap_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= w;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		sent_count++;
	endtask

	initial begin
		cmd_word_t w;
		int pick;
		int taken;
		bit counts;
		int gap_pct [4] = '{0, 49, 0, 23};
		int stall_pct [4] = '{0, 0, 49, 23};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty fetch, field extremes, out-of-range slots, delay clamping, stop and ticks.
		send_word(make_word(KIND_FETCH, TYPE_APP, 0, 0, 0));
		send_word(make_word(KIND_POST, TYPE_APP, 0, 0, 0));
		send_word(make_word(KIND_POST, TYPE_APP, APP_SLOTS - 1, 'hFF, 0));
		send_word(make_word(KIND_POST, TYPE_TIMER, TIMER_SLOTS - 1, 'hA5, 0));
		send_word(make_word(KIND_POST, TYPE_APP, APP_SLOTS, 'h11, 0));
		send_word(make_word(KIND_POST, TYPE_TIMER, 63, 'h22, 0));
		send_word(make_word(KIND_START, TYPE_TIMER, 0, 0, 'hFFFF));
		send_word(make_word(KIND_START, TYPE_TIMER, 1, 0, 15));
		send_word(make_word(KIND_START, TYPE_TIMER, 2, 0, 16));
		send_word(make_word(KIND_START, TYPE_TIMER, 3, 0, 32));
		send_word(make_word(KIND_START, TYPE_TIMER, 63, 'hFF, 100));
		send_word(make_word(KIND_STOP, TYPE_TIMER, 3, 0, 0));
		send_word(make_word(KIND_STOP, TYPE_TIMER, 63, 0, 0));
		send_word(make_word(KIND_TICK, TYPE_APP, 0, 0, 0));
		send_word(make_word(kind_t'(KIND_RSVD_LO), TYPE_TIMER, 63, 'hFF, 'hFFFF));
		send_word(make_word(kind_t'(KIND_RSVD_HI), TYPE_APP, 0, 0, 0));
		send_word(make_word(KIND_TICK, TYPE_TIMER, 63, 'hFF, 'hFFFF));
		repeat (5)
			send_word(make_word(KIND_FETCH, TYPE_APP, 0, 0, 0));
		send_word(make_word(KIND_STOP, TYPE_TIMER, 0, 0, 0));
		send_word(make_word(KIND_POST, TYPE_TIMER, 4, 'h5A, 0));
		send_word(make_word(KIND_FETCH, TYPE_TIMER, 63, 'hFF, 'hFFFF));

		// Pressure: the reply side holds off while posts and fetches keep coming.
		hold_off_req = 1'b1;
		for (int i = 0; i < 6; i++) begin
			send_word(make_word(KIND_POST, TYPE_APP, i, $urandom_range(255), 0));
			send_word(make_word(KIND_FETCH, TYPE_APP, 0, 0, 0));
		end

		// Random mix over four phases of sender gaps and reply stalls; short delays so timers fire often.
		for (int p = 0; p < 4; p++) begin
			send_gap_pct = gap_pct[p];
			reply_stall_pct = stall_pct[p];
			taken = 0;
			while (taken < PHASE_ITEMS) begin
				w.task_type = 1'($urandom_range(1));
				w.task_arg = ARG_W'($urandom_range(255));
				w.delay_ms = ($urandom_range(9) == 0) ? DELAY_W'($urandom_range(65535))
					: DELAY_W'($urandom_range(200));
				w.task_index = ($urandom_range(9) == 0) ? IDX_W'($urandom_range(63))
					: IDX_W'($urandom_range(APP_SLOTS - 1));
				pick = $urandom_range(99);
				if (pick < 25)
					w.kind = KIND_TICK;
				else if (pick < 50)
					w.kind = KIND_POST;
				else if (pick < 64)
					w.kind = KIND_START;
				else if (pick < 70)
					w.kind = KIND_STOP;
				else if (pick < 97)
					w.kind = KIND_FETCH;
				else
					w.kind = kind_t'($urandom_range(KIND_RSVD_HI, KIND_RSVD_LO));
				case (w.kind)
					KIND_TICK, KIND_FETCH: counts = 1'b1;
					KIND_POST: counts = w.task_index <
						((w.task_type == TYPE_APP) ? APP_SLOTS : TIMER_SLOTS);
					KIND_START, KIND_STOP: counts = w.task_index < TIMER_SLOTS;
					default: counts = 1'b0;
				endcase
				send_word(w);
				if (counts)
					taken++;
			end
		end
		cmd_valid <= 1'b0;

		// Drain: wait for every owed reply, then let the block settle.
		do
			@(posedge clk);
		while (waiting != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d command words: %0d fetches served a task, %0d found nothing.",
			sent_count, served_count, empty_count);
		$display("Phases: no gaps, sender gaps, reply stalls, both, one long reply hold-off.");
		if (fail_count == 0)
			$display("pending_task_dispatch_with_timers regression: pass");
		else
			$display("pending_task_dispatch_with_timers regression: fail");
		$finish;
	end

endmodule
